@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the ordered insert queue.
// Expects clk and rst_n to be in scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ sv/oiq_pkg.sv @@
// Package of the ordered insert queue: sizes, field types and codes.
// No dependencies.
package oiq_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 64;
    localparam int ITEM_W      = 64;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [ITEM_W-1:0]      item_t;
    typedef logic [CNT_W-1:0]       count_t;
    typedef logic [IDX_W-1:0]       index_t;
    typedef logic [1:0]             command_t;
    typedef logic [1:0]             status_t;

    localparam command_t CMD_INSERT = 2'd0;
    localparam command_t CMD_REMOVE = 2'd1;
    localparam command_t CMD_CLEAR  = 2'd2;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

endpackage

@@ sv/oiq_channels.sv @@
// Valid/ready channel interfaces of the ordered insert queue.
// Depends on oiq_pkg.
interface oiq_in_if;
    import oiq_pkg::*;

    logic     valid;
    logic     ready;
    command_t command;
    item_t    item_value;

    modport source (output valid, output command, output item_value, input ready);
    modport sink   (input valid, input command, input item_value, output ready);
endinterface

interface oiq_out_if;
    import oiq_pkg::*;

    logic    valid;
    logic    ready;
    item_t   out_value;
    logic    out_valid;
    status_t status;
    count_t  occupancy_count;
    logic    is_empty;

    modport source (output valid, output out_value, output out_valid, output status,
                    output occupancy_count, output is_empty, input ready);
    modport sink   (input valid, input out_value, input out_valid, input status,
                    input occupancy_count, input is_empty, output ready);
endinterface

@@ sv/ordered_insert_queue.sv @@
// Bounded queue of CAPACITY values with FIFO and ascending-ordered modes.
// Commands arrive on a valid/ready channel, one result per command leaves on
// another. Depends on oiq_pkg, oiq_channels and assert_macros.svh.
//
// Entries live in a single-port-read, single-port-write memory with a
// registered read; a small sequencer walks it one entry at a time, each
// step a memory read followed by compare or write-back, and the input is
// not ready meanwhile. Clear, an unused command, an insert into a full
// queue and a remove on an empty queue go straight to the result. A FIFO
// insert writes the value at the tail. An ordered insert compares entries
// from the front, then moves the larger-or-equal ones back one place from
// the tail and writes the value. A remove reads the head and moves each
// remaining entry forward one place. The result register loads as the
// sequencer returns to idle; if an earlier result has not been taken yet,
// the sequencer stalls until it is. A finished result waits in the output
// register while the next command is taken.
module ordered_insert_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    oiq_in_if.sink               in_ch,
    oiq_out_if.source            out_ch
);
    import oiq_pkg::*;

`include "assert_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PUT,
        ST_REM_HEAD_RD,
        ST_REM_HEAD,
        ST_REM_RD,
        ST_REM_WR,
        ST_DONE
    } state_t;

    state_t  state_reg;
    count_t  count_reg;
    logic    mode_reg;
    count_t  idx_reg;
    index_t  pos_reg;
    value_t  val_reg;

    value_t  res_value_reg;
    logic    res_valid_reg;
    status_t res_status_reg;

    logic    ovalid_reg;
    value_t  oval_reg;
    logic    ovflag_reg;
    status_t ostatus_reg;
    count_t  ocount_reg;

    value_t  mem [CAPACITY];
    value_t  rd_data_reg;
    logic    mem_we;
    index_t  mem_waddr;
    value_t  mem_wdata;
    index_t  rd_addr;

    index_t  idx_lo;
    index_t  idx_m1;
    count_t  idx_p1;
    logic    in_xfer;
    logic    res_load;

    assign idx_lo   = idx_reg[IDX_W-1:0];
    assign idx_m1   = idx_lo - index_t'(1);
    assign idx_p1   = idx_reg + count_t'(1);
    assign in_xfer  = in_ch.valid && in_ch.ready;
    // result register is free or being emptied this cycle
    assign res_load = (state_reg == ST_DONE) && (!ovalid_reg || out_ch.ready);

    assign in_ch.ready            = (state_reg == ST_IDLE);
    assign out_ch.valid           = ovalid_reg;
    assign out_ch.out_value       = ITEM_W'(oval_reg);
    assign out_ch.out_valid       = ovflag_reg;
    assign out_ch.status          = ostatus_reg;
    assign out_ch.occupancy_count = ocount_reg;
    assign out_ch.is_empty        = (ocount_reg == '0);

    // memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_lo;
        mem_wdata = rd_data_reg;
        rd_addr   = idx_lo;
        unique case (state_reg)
            ST_SHIFT_RD: rd_addr = idx_m1;
            ST_SHIFT_WR: mem_we = 1'b1;
            ST_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                mem_wdata = val_reg;
            end
            ST_REM_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_m1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            mode_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_wdata;
            if (res_load)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        val_reg       <= in_ch.item_value[VALUE_WIDTH-1:0];
                        res_value_reg <= '0;
                        res_valid_reg <= 1'b0;
                        unique case (in_ch.command)
                            CMD_INSERT:
                            begin
                                if (count_reg == count_t'(CAPACITY))
                                begin
                                    res_status_reg <= STATUS_FULL;
                                    state_reg      <= ST_DONE;
                                end
                                else if (mode_reg && count_reg != '0)
                                begin
                                    res_status_reg <= STATUS_OK;
                                    idx_reg        <= '0;
                                    state_reg      <= ST_SCAN_RD;
                                end
                                else
                                begin
                                    res_status_reg <= STATUS_OK;
                                    pos_reg        <= count_reg[IDX_W-1:0];
                                    idx_reg        <= count_reg;
                                    state_reg      <= ST_SHIFT_RD;
                                end
                            end
                            CMD_REMOVE:
                            begin
                                if (count_reg == '0)
                                begin
                                    res_status_reg <= STATUS_EMPTY;
                                    state_reg      <= ST_DONE;
                                end
                                else
                                begin
                                    res_status_reg <= STATUS_OK;
                                    idx_reg        <= '0;
                                    state_reg      <= ST_REM_HEAD_RD;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                res_status_reg <= STATUS_OK;
                                count_reg      <= '0;
                                state_reg      <= ST_DONE;
                            end
                            default:
                            begin
                                res_status_reg <= STATUS_OK;
                                state_reg      <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SCAN_RD: state_reg <= ST_SCAN_CMP;
                ST_SCAN_CMP:
                begin
                    // first entry not smaller wins, so the new value goes ahead of equal values
                    if (rd_data_reg >= val_reg)
                    begin
                        pos_reg   <= idx_lo;
                        idx_reg   <= count_reg;
                        state_reg <= ST_SHIFT_RD;
                    end
                    else if (idx_p1 == count_reg)
                    begin
                        pos_reg   <= count_reg[IDX_W-1:0];
                        idx_reg   <= count_reg;
                        state_reg <= ST_SHIFT_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_p1;
                        state_reg <= ST_SCAN_RD;
                    end
                end
                ST_SHIFT_RD:
                begin
                    if (idx_lo == pos_reg)
                        state_reg <= ST_PUT;
                    else
                        state_reg <= ST_SHIFT_WR;
                end
                ST_SHIFT_WR:
                begin
                    idx_reg   <= idx_reg - count_t'(1);
                    state_reg <= ST_SHIFT_RD;
                end
                ST_PUT:
                begin
                    count_reg <= count_reg + count_t'(1);
                    state_reg <= ST_DONE;
                end
                ST_REM_HEAD_RD: state_reg <= ST_REM_HEAD;
                ST_REM_HEAD:
                begin
                    res_value_reg <= rd_data_reg;
                    res_valid_reg <= 1'b1;
                    idx_reg       <= count_t'(1);
                    state_reg     <= ST_REM_RD;
                end
                ST_REM_RD:
                begin
                    if (idx_reg == count_reg)
                    begin
                        count_reg <= count_reg - count_t'(1);
                        state_reg <= ST_DONE;
                    end
                    else
                        state_reg <= ST_REM_WR;
                end
                ST_REM_WR:
                begin
                    idx_reg   <= idx_p1;
                    state_reg <= ST_REM_RD;
                end
                ST_DONE:
                begin
                    // hold until the previous result has been taken
                    if (res_load)
                    begin
                        oval_reg    <= res_value_reg;
                        ovflag_reg  <= res_valid_reg;
                        ostatus_reg <= res_status_reg;
                        ocount_reg  <= count_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_IMP(a_count_bound, 1'b1, count_reg <= count_t'(CAPACITY))
    `ASSERT_IMP(a_removed_ok, ovalid_reg && ovflag_reg, ostatus_reg == STATUS_OK)
    `ASSERT_NXT(a_full_drop,
                in_xfer && in_ch.command == CMD_INSERT && count_reg == count_t'(CAPACITY),
                $stable(count_reg))
    `ASSERT_IMP(a_empty_no_remove, ovalid_reg && ostatus_reg == STATUS_EMPTY, !ovflag_reg && ocount_reg == '0)

endmodule
